>>> hw/rtl/tsl_pkg.sv
// tsl_pkg: shared constants, types and the pair update rule of the
// two-species lattice. No dependencies; used by the request and config
// interfaces, the top level and the bench.
package tsl_pkg;

	// lattice geometry: sites are split over an even bank and an odd bank
	localparam int SITES      = 1024;
	localparam int SITE_BITS  = $clog2(SITES);
	localparam int BANK_DEPTH = SITES / 2;
	localparam int BANK_BITS  = $clog2(BANK_DEPTH);

	// draw and threshold widths
	localparam int DRAW_BITS = 16;
	localparam int RATE_BITS = 16;

	// configuration register indexes and reset values
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BETA  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GAMMA = 2'd2;

	localparam logic [RATE_BITS-1:0] ALPHA_RESET = 16'd9765;
	localparam logic [RATE_BITS-1:0] BETA_RESET  = 16'd1311;
	localparam logic [RATE_BITS-1:0] GAMMA_RESET = 16'd58982;

	// operations carried by a request beat
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_UPDATE = 2'd1,
		OP_READ   = 2'd2
	} opcode_t;

	// pair patterns, bit order first_i first_j second_i second_j
	localparam logic [3:0] PAT_0000 = 4'b0000;
	localparam logic [3:0] PAT_0011 = 4'b0011;
	localparam logic [3:0] PAT_0100 = 4'b0100;
	localparam logic [3:0] PAT_0110 = 4'b0110;
	localparam logic [3:0] PAT_0111 = 4'b0111;
	localparam logic [3:0] PAT_1000 = 4'b1000;
	localparam logic [3:0] PAT_1001 = 4'b1001;
	localparam logic [3:0] PAT_1010 = 4'b1010;
	localparam logic [3:0] PAT_1011 = 4'b1011;
	localparam logic [3:0] PAT_1100 = 4'b1100;
	localparam logic [3:0] PAT_1101 = 4'b1101;
	localparam logic [3:0] PAT_1110 = 4'b1110;
	localparam logic [3:0] PAT_1111 = 4'b1111;

	typedef struct packed {
		logic       hit;
		logic [3:0] pat;
	} pair_next_t;

	// transition rule; inputs are the threshold test outcomes
	function automatic pair_next_t pair_next(
		input logic [3:0] pat,
		input logic       alpha_one,
		input logic       beta_one,
		input logic       gamma_one,
		input logic       beta_two
	);
		pair_next_t r;
		r.hit = 1'b0;
		r.pat = pat;
		case (pat)
			PAT_1000: if (alpha_one) r = '{1'b1, PAT_1100};
			PAT_1001: if (alpha_one) r = '{1'b1, PAT_1101};
			PAT_1010: if (alpha_one) r = '{1'b1, PAT_1110};
			PAT_1011: begin
				if (alpha_one)     r = '{1'b1, PAT_1111};
				else if (beta_two) r = '{1'b1, PAT_1000};
			end
			PAT_1110: if (gamma_one) r = '{1'b1, PAT_1011};
			PAT_1111: if (beta_one)  r = '{1'b1, PAT_1100};
			PAT_0011: if (beta_one)  r = '{1'b1, PAT_0000};
			PAT_0110: if (gamma_one) r = '{1'b1, PAT_0011};
			PAT_0111: if (beta_one)  r = '{1'b1, PAT_0100};
			default: ;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/tsl_req_if.sv
// tsl_req_if: request channel of the lattice, valid/ready plus one item.
// Depends on tsl_pkg.
interface tsl_req_if;
	import tsl_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           opcode;
	logic [SITE_BITS-1:0] site_index;
	logic                 write_first;
	logic                 write_second;
	logic [DRAW_BITS-1:0] draw_one;
	logic [DRAW_BITS-1:0] draw_two;

	modport source (output valid, opcode, site_index, write_first, write_second,
		draw_one, draw_two, input ready);
	modport sink (input valid, opcode, site_index, write_first, write_second,
		draw_one, draw_two, output ready);
endinterface

>>> hw/rtl/tsl_rsp_if.sv
// tsl_rsp_if: response channel of the lattice, valid/ready plus one result.
// No dependencies.
interface tsl_rsp_if;
	logic valid;
	logic ready;
	logic first_at_i;
	logic second_at_i;
	logic first_at_j;
	logic second_at_j;
	logic pair_changed;

	modport source (output valid, first_at_i, second_at_i, first_at_j,
		second_at_j, pair_changed, input ready);
	modport sink (input valid, first_at_i, second_at_i, first_at_j,
		second_at_j, pair_changed, output ready);
endinterface

>>> hw/rtl/tsl_cfg_if.sv
// tsl_cfg_if: register write channel, valid/ready plus index and data.
// Depends on tsl_pkg.
interface tsl_cfg_if;
	import tsl_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [RATE_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/two_species_pair_update_lattice.sv
// two_species_pair_update_lattice: ring lattice of two-species occupancy
// bits with write, read and stochastic pair update operations.
// Depends on tsl_pkg, tsl_req_if, tsl_rsp_if, tsl_cfg_if and tsl_ram.
//
// Usage:
//   req carries one operation per beat: write site, update pair or read pair
//   on site i and its ring neighbour j = i+1. rsp returns one beat per
//   request, in order, with the four bits of i and j after the operation and
//   a flag when an update rewrote the pair. cfg writes the alpha, beta and
//   gamma thresholds (index 0..2, others ignored); cfg.ready is always high.
//   A request beat passes through the request register, where the banks are
//   read and the pair rewritten, then the response register. One request is
//   taken every cycle unless the clear sweep runs or the response stalls; sites
//   live in an even and an odd bank, so a pair is one read and at most one
//   write per bank, and a write still in flight is forwarded to the following
//   beat. After reset both banks are swept to zero, one row per cycle over
//   all 512 rows, with req.ready low; thresholds take reset values at once.
//   When the receiver stalls, the response register holds its beat, the
//   request register fills and req.ready drops until rsp.ready returns.
module two_species_pair_update_lattice (
	input logic  clk,
	input logic  arst_n,
	tsl_req_if.sink   req,
	tsl_rsp_if.source rsp,
	tsl_cfg_if.sink   cfg
);
	import tsl_pkg::*;

	// threshold registers
	logic [RATE_BITS-1:0] alpha_q, beta_q, gamma_q;

	// clear sweep
	logic                 clr_busy_q;
	logic [BANK_BITS-1:0] clr_addr_q;

	// request stage
	logic                 v_s1;
	logic [1:0]           op_s1;
	logic                 odd_s1;
	logic [BANK_BITS-1:0] even_addr_s1, odd_addr_s1;
	logic                 wf_s1, ws_s1;
	logic [DRAW_BITS-1:0] d1_s1, d2_s1;

	// last write per bank, for forwarding
	logic                 byp_e_v_q, byp_o_v_q;
	logic [BANK_BITS-1:0] byp_e_addr_q, byp_o_addr_q;
	logic [1:0]           byp_e_data_q, byp_o_data_q;

	// response register
	logic       rsp_v_q;
	logic [3:0] rsp_pat_q;
	logic       rsp_chg_q;

	logic                 acc, adv, fire;
	logic [BANK_BITS-1:0] even_raddr, odd_raddr;
	logic [1:0]           e_rdata, o_rdata, e_cur, o_cur;
	logic [1:0]           site_i, site_j, new_i, new_j;
	logic [3:0]           pat, pat_new;
	logic                 chg;
	pair_next_t           nxt;
	logic                 e_we, o_we;
	logic [BANK_BITS-1:0] e_waddr, o_waddr;
	logic [1:0]           e_wdata, o_wdata;

	// handshakes
	assign adv       = !rsp_v_q || rsp.ready;
	assign fire      = v_s1 && adv;
	assign req.ready = !clr_busy_q && (!v_s1 || adv);
	assign acc       = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// bank read addresses: j of an odd site sits one row up in the even bank
	assign odd_raddr  = req.site_index[SITE_BITS-1:1];
	assign even_raddr = req.site_index[0] ? odd_raddr + 1'b1 : odd_raddr;

	tsl_ram #(.WIDTH(2), .DEPTH(BANK_DEPTH)) u_even (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.re(acc), .raddr(even_raddr), .rdata(e_rdata)
	);

	tsl_ram #(.WIDTH(2), .DEPTH(BANK_DEPTH)) u_odd (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.re(acc), .raddr(odd_raddr), .rdata(o_rdata)
	);

	// forward the latest bank write over the read data
	assign e_cur = (byp_e_v_q && byp_e_addr_q == even_addr_s1) ? byp_e_data_q : e_rdata;
	assign o_cur = (byp_o_v_q && byp_o_addr_q == odd_addr_s1) ? byp_o_data_q : o_rdata;

	// bank entries are {first, second}
	assign site_i = odd_s1 ? o_cur : e_cur;
	assign site_j = odd_s1 ? e_cur : o_cur;
	assign pat    = {site_i[1], site_j[1], site_i[0], site_j[0]};

	assign nxt = pair_next(pat, d1_s1 < alpha_q, d1_s1 < beta_q,
		d1_s1 < gamma_q, d2_s1 < beta_q);

	// apply the operation
	always_comb begin
		pat_new = pat;
		chg     = 1'b0;
		case (op_s1)
			OP_WRITE: begin
				pat_new = {wf_s1, pat[2], ws_s1, pat[0]};
			end
			OP_UPDATE: begin
				pat_new = nxt.pat;
				chg     = nxt.hit;
			end
			default: ;
		endcase
	end

	assign new_i = {pat_new[3], pat_new[1]};
	assign new_j = {pat_new[2], pat_new[0]};

	// bank writes: sweep after reset, else the retiring request
	always_comb begin
		if (clr_busy_q) begin
			e_we    = 1'b1;
			o_we    = 1'b1;
			e_waddr = clr_addr_q;
			o_waddr = clr_addr_q;
			e_wdata = 2'b00;
			o_wdata = 2'b00;
		end else begin
			e_we    = fire && ((op_s1 == OP_WRITE && !odd_s1) || chg);
			o_we    = fire && ((op_s1 == OP_WRITE && odd_s1) || chg);
			e_waddr = even_addr_s1;
			o_waddr = odd_addr_s1;
			e_wdata = odd_s1 ? new_j : new_i;
			o_wdata = odd_s1 ? new_i : new_j;
		end
	end

	// thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			beta_q  <= BETA_RESET;
			gamma_q <= GAMMA_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ALPHA: alpha_q <= cfg.data;
				CFG_BETA:  beta_q  <= cfg.data;
				CFG_GAMMA: gamma_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == BANK_BITS'(BANK_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// forwarding registers track every bank write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_e_v_q <= 1'b0;
			byp_o_v_q <= 1'b0;
		end else begin
			if (e_we) byp_e_v_q <= 1'b1;
			if (o_we) byp_o_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			byp_e_addr_q <= e_waddr;
			byp_e_data_q <= e_wdata;
		end
		if (o_we) begin
			byp_o_addr_q <= o_waddr;
			byp_o_data_q <= o_wdata;
		end
	end

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1        <= req.opcode;
			odd_s1       <= req.site_index[0];
			even_addr_s1 <= even_raddr;
			odd_addr_s1  <= odd_raddr;
			wf_s1        <= req.write_first;
			ws_s1        <= req.write_second;
			d1_s1        <= req.draw_one;
			d2_s1        <= req.draw_two;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (fire) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_pat_q <= pat_new;
			rsp_chg_q <= chg;
		end
	end

	assign rsp.valid        = rsp_v_q;
	assign rsp.first_at_i   = rsp_pat_q[3];
	assign rsp.first_at_j   = rsp_pat_q[2];
	assign rsp.second_at_i  = rsp_pat_q[1];
	assign rsp.second_at_j  = rsp_pat_q[0];
	assign rsp.pair_changed = rsp_chg_q;
endmodule

>>> hw/rtl/tsl_ram.sv
// tsl_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
module tsl_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and read-first registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> hw/rtl/tsl_checker.sv
// tsl_checker: port-level assertions for the lattice, bound to the top
// level. Depends on tsl_req_if, tsl_rsp_if and two_species_pair_update_lattice.
module tsl_checker (
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic first_at_i,
	input logic second_at_i,
	input logic first_at_j,
	input logic second_at_j,
	input logic pair_changed
);
	logic [3:0] pat;

	assign pat = {first_at_i, first_at_j, second_at_i, second_at_j};

	// a stalled response beat stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	// a stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(pat) && $stable(pair_changed))
		else $error("response payload changed while stalled");

	// the clear sweep blocks requests right after reset
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !req_ready)
		else $error("request taken before clear sweep");

	// a rewritten pair always lands on a transition target
	a_changed_target: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && pair_changed |->
			pat == 4'b1100 || pat == 4'b1101 || pat == 4'b1110 ||
			pat == 4'b1111 || pat == 4'b1000 || pat == 4'b0000 ||
			pat == 4'b0100 || pat == 4'b0011 || pat == 4'b1011)
		else $error("changed pair is not a transition target");
endmodule

bind two_species_pair_update_lattice tsl_checker u_tsl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.first_at_i(rsp.first_at_i),
	.second_at_i(rsp.second_at_i),
	.first_at_j(rsp.first_at_j),
	.second_at_j(rsp.second_at_j),
	.pair_changed(rsp.pair_changed)
);

>>> test/two_species_pair_update_lattice_tb.sv
`timescale 1ns / 1ps
// two_species_pair_update_lattice_tb: self-checking bench for the lattice, with
// directed and random traffic, a local lattice predictor and an in-order checker.
// Depends on tsl_pkg, tsl_req_if, tsl_rsp_if, tsl_cfg_if and the lattice RTL.
module two_species_pair_update_lattice_tb;
	import tsl_pkg::*;

	// codes outside the package lists
	localparam logic [1:0]              OP_SPARE  = 2'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

	localparam int WATCHDOG_CYCLES = 4000;
	localparam int PAIR_SITE       = 100;

	// expected view of one response beat
	typedef struct packed {
		logic first_i;
		logic second_i;
		logic first_j;
		logic second_j;
		logic changed;
	} pair_view_t;

	logic clk = 1'b0;
	logic arst_n;

	tsl_req_if req_ch ();
	tsl_rsp_if rsp_ch ();
	tsl_cfg_if cfg_ch ();

	two_species_pair_update_lattice dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #10 clk = ~clk;

	// predicted lattice contents and thresholds
	bit                   occ_first [SITES];
	bit                   occ_second [SITES];
	logic [RATE_BITS-1:0] rate_alpha = ALPHA_RESET;
	logic [RATE_BITS-1:0] rate_beta  = BETA_RESET;
	logic [RATE_BITS-1:0] rate_gamma = GAMMA_RESET;

	pair_view_t pending_views[$];
	int         mismatches = 0;
	int         items_sent = 0;
	bit         idle_on = 1'b1;

	// apply one operation to the predicted lattice and return the pair view
	function automatic pair_view_t predict_pair(
		input logic [1:0]           op,
		input logic [SITE_BITS-1:0] site,
		input logic                 wr_first,
		input logic                 wr_second,
		input logic [DRAW_BITS-1:0] draw_a,
		input logic [DRAW_BITS-1:0] draw_b
	);
		int unsigned i;
		int unsigned j;
		logic [3:0]  pat;
		logic [3:0]  nxt;
		logic        hit;
		pair_view_t  v;
		i = site % SITES;
		j = (i + 1 == SITES) ? 0 : i + 1;
		hit = 1'b0;
		nxt = '0;
		if (op == OP_WRITE) begin
			occ_first[i] = wr_first;
			occ_second[i] = wr_second;
		end else if (op == OP_UPDATE) begin
			pat = {occ_first[i], occ_first[j], occ_second[i], occ_second[j]};
			case (pat)
				PAT_1000: if (draw_a < rate_alpha) {hit, nxt} = {1'b1, PAT_1100};
				PAT_1001: if (draw_a < rate_alpha) {hit, nxt} = {1'b1, PAT_1101};
				PAT_1010: if (draw_a < rate_alpha) {hit, nxt} = {1'b1, PAT_1110};
				PAT_1011: begin
					// second draw only matters when the alpha test fails
					if (draw_a < rate_alpha)
						{hit, nxt} = {1'b1, PAT_1111};
					else if (draw_b < rate_beta)
						{hit, nxt} = {1'b1, PAT_1000};
				end
				PAT_1110: if (draw_a < rate_gamma) {hit, nxt} = {1'b1, PAT_1011};
				PAT_1111: if (draw_a < rate_beta)  {hit, nxt} = {1'b1, PAT_1100};
				PAT_0011: if (draw_a < rate_beta)  {hit, nxt} = {1'b1, PAT_0000};
				PAT_0110: if (draw_a < rate_gamma) {hit, nxt} = {1'b1, PAT_0011};
				PAT_0111: if (draw_a < rate_beta)  {hit, nxt} = {1'b1, PAT_0100};
				default: ;
			endcase
			if (hit)
				{occ_first[i], occ_first[j], occ_second[i], occ_second[j]} = nxt;
		end
		v = '{occ_first[i], occ_second[i], occ_first[j], occ_second[j], hit};
		return v;
	endfunction

	// draws spread over the full range, small values, threshold edges and the extremes
	function automatic logic [DRAW_BITS-1:0] pick_draw();
		logic [RATE_BITS-1:0] r;
		case ($urandom_range(0, 2))
			0: r = rate_alpha;
			1: r = rate_beta;
			default: r = rate_gamma;
		endcase
		case ($urandom_range(0, 3))
			0: return DRAW_BITS'($urandom_range(0, 65535));
			1: return DRAW_BITS'($urandom_range(0, 2047));
			2: return DRAW_BITS'(r + $urandom_range(0, 2) - 1);
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	// sites near both ends of the ring plus any site, so pairs get reused and wrap
	function automatic logic [SITE_BITS-1:0] pick_site();
		case ($urandom_range(0, 3))
			0: return SITE_BITS'(SITES - 1);
			1, 2: return SITE_BITS'($urandom_range(0, 31));
			default: return SITE_BITS'($urandom_range(0, SITES - 1));
		endcase
	endfunction

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			mismatches++;
		end
	endfunction

	// one request beat; valid stays high on return so beats can go back to back
	task automatic send_item(
		input logic [1:0]           op,
		input logic [SITE_BITS-1:0] site,
		input logic                 wr_first,
		input logic                 wr_second,
		input logic [DRAW_BITS-1:0] draw_a,
		input logic [DRAW_BITS-1:0] draw_b
	);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.site_index <= site;
		req_ch.write_first <= wr_first;
		req_ch.write_second <= wr_second;
		req_ch.draw_one <= draw_a;
		req_ch.draw_two <= draw_b;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		pending_views.push_back(predict_pair(op, site, wr_first, wr_second, draw_a, draw_b));
		items_sent++;
	endtask

	// stop sending and wait for every pending response
	task automatic settle();
		if (req_ch.valid) req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_views.size() != 0);
	endtask

	// one register write; the caller lowers valid after its last write
	task automatic write_rate(input logic [CFG_IDX_BITS-1:0] idx, input logic [RATE_BITS-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		case (idx)
			CFG_ALPHA: rate_alpha = val;
			CFG_BETA: rate_beta = val;
			CFG_GAMMA: rate_gamma = val;
			default: ;
		endcase
	endtask

	task automatic set_rates(
		input logic [RATE_BITS-1:0] alpha,
		input logic [RATE_BITS-1:0] beta,
		input logic [RATE_BITS-1:0] gamma
	);
		write_rate(CFG_ALPHA, alpha);
		write_rate(CFG_BETA, beta);
		write_rate(CFG_GAMMA, gamma);
		// unused index must leave all thresholds alone
		write_rate(CFG_SPARE, RATE_BITS'($urandom_range(0, 65535)));
		cfg_ch.valid <= 1'b0;
	endtask

	// writes, reads, updates, the spare opcode and a pair that wraps around the ring
	task automatic test_write_read();
		send_item(OP_WRITE, '0, 1'b1, 1'b1, 16'h0000, 16'hFFFF);
		send_item(OP_WRITE, SITE_BITS'(SITES - 1), 1'b1, 1'b0, 16'hFFFF, 16'h0000);
		send_item(OP_READ, SITE_BITS'(SITES - 1), 1'b0, 1'b1, 16'h0000, 16'h0000);
		send_item(OP_SPARE, SITE_BITS'(SITES - 1), 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
		send_item(OP_UPDATE, SITE_BITS'(SITES - 1), 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_item(OP_WRITE, SITE_BITS'(SITES - 1), 1'b1, 1'b1, 16'h0000, 16'h0000);
		send_item(OP_WRITE, '0, 1'b0, 1'b1, 16'h0000, 16'h0000);
		send_item(OP_UPDATE, SITE_BITS'(SITES - 1), 1'b0, 1'b0, 16'h0000, 16'hFFFF);
		send_item(OP_READ, '0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF);
	endtask

	// transitions at the reset thresholds, including the case 11 fallback
	task automatic test_pair_rules();
		logic [SITE_BITS-1:0] si;
		logic [SITE_BITS-1:0] sj;
		si = SITE_BITS'(PAIR_SITE);
		sj = SITE_BITS'(PAIR_SITE + 1);
		// alpha just passes, then a case with no rule
		send_item(OP_WRITE, si, 1'b1, 1'b0, 16'h0000, 16'h0000);
		send_item(OP_WRITE, sj, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_item(OP_UPDATE, si, 1'b0, 1'b0, ALPHA_RESET - 1'b1, 16'hFFFF);
		send_item(OP_UPDATE, si, 1'b0, 1'b0, 16'h0000, 16'h0000);
		// draw equal to alpha fails, second draw passes beta
		send_item(OP_WRITE, si, 1'b1, 1'b1, 16'h0000, 16'h0000);
		send_item(OP_WRITE, sj, 1'b0, 1'b1, 16'h0000, 16'h0000);
		send_item(OP_UPDATE, si, 1'b0, 1'b0, ALPHA_RESET, BETA_RESET - 1'b1);
		// both tests fail, then alpha, then beta from the full pair
		send_item(OP_WRITE, sj, 1'b0, 1'b1, 16'h0000, 16'h0000);
		send_item(OP_WRITE, si, 1'b1, 1'b1, 16'h0000, 16'h0000);
		send_item(OP_UPDATE, si, 1'b0, 1'b0, 16'hFFFF, BETA_RESET);
		send_item(OP_UPDATE, si, 1'b0, 1'b0, 16'h0000, 16'h0000);
		send_item(OP_UPDATE, si, 1'b0, 1'b0, BETA_RESET - 1'b1, 16'h0000);
		// gamma just passes
		send_item(OP_WRITE, si, 1'b1, 1'b1, 16'h0000, 16'h0000);
		send_item(OP_WRITE, sj, 1'b1, 1'b0, 16'h0000, 16'h0000);
		send_item(OP_UPDATE, si, 1'b0, 1'b0, GAMMA_RESET - 1'b1, 16'h0000);
	endtask

	// mostly set-pair-then-update sequences, some chained updates and noise
	task automatic test_random_traffic(input int count);
		int                   target;
		int                   kind;
		logic [SITE_BITS-1:0] site;
		target = items_sent + count;
		while (items_sent < target) begin
			kind = $urandom_range(0, 9);
			site = pick_site();
			if (kind < 6) begin
				send_item(OP_WRITE, site, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					pick_draw(), pick_draw());
				send_item(OP_WRITE, site + 1'b1, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), pick_draw(), pick_draw());
				repeat ($urandom_range(1, 3))
					send_item(OP_UPDATE, site, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), pick_draw(), pick_draw());
				if ($urandom_range(0, 1))
					send_item(OP_READ, site, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), pick_draw(), pick_draw());
			end else if (kind < 8) begin
				send_item(OP_UPDATE, site, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					pick_draw(), pick_draw());
			end else if (kind == 8 || $urandom_range(0, 15) != 0) begin
				send_item(2'($urandom_range(0, 3)), SITE_BITS'($urandom_range(0, SITES - 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					DRAW_BITS'($urandom_range(0, 65535)), DRAW_BITS'($urandom_range(0, 65535)));
			end else begin
				settle();
			end
		end
	endtask

	// response ready with random stall bursts
	initial begin : rsp_stall
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// compare each response beat with the oldest prediction
	always @(posedge clk) begin
		pair_view_t want;
		if (arst_n === 1'b1 && (rsp_ch.valid & rsp_ch.ready) === 1'b1) begin
			if (pending_views.size() == 0) begin
				$error("response beat with no prediction pending");
				mismatches++;
			end else begin
				want = pending_views.pop_front();
				check_field("first_at_i", want.first_i, rsp_ch.first_at_i);
				check_field("second_at_i", want.second_i, rsp_ch.second_at_i);
				check_field("first_at_j", want.first_j, rsp_ch.first_at_j);
				check_field("second_at_j", want.second_j, rsp_ch.second_at_j);
				check_field("pair_changed", want.changed, rsp_ch.pair_changed);
			end
		end
	end

	// end the run when no channel moves a beat for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((req_ch.valid & req_ch.ready) === 1'b1 || (rsp_ch.valid & rsp_ch.ready) === 1'b1
				|| (cfg_ch.valid & cfg_ch.ready) === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// test sequence
	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_READ;
		req_ch.site_index <= '0;
		req_ch.write_first <= 1'b0;
		req_ch.write_second <= 1'b0;
		req_ch.draw_one <= '0;
		req_ch.draw_two <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_ALPHA;
		cfg_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_write_read();
		test_pair_rules();
		settle();

		set_rates('1, '1, '1);
		test_random_traffic(300);
		settle();

		set_rates('0, '0, '0);
		test_random_traffic(250);
		settle();

		set_rates(RATE_BITS'($urandom_range(0, 65535)), RATE_BITS'($urandom_range(0, 65535)),
			RATE_BITS'($urandom_range(0, 65535)));
		test_random_traffic(300);
		settle();

		set_rates(ALPHA_RESET, BETA_RESET, GAMMA_RESET);
		test_random_traffic(280);
		settle();

		// last stretch runs at full rate on both sides
		idle_on = 1'b0;
		set_rates(RATE_BITS'($urandom_range(0, 65535)), RATE_BITS'($urandom_range(0, 4095)),
			RATE_BITS'($urandom_range(0, 65535)));
		test_random_traffic(400);
		settle();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_views.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
